>>> rtl/core/rppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rppd_pkg;

	localparam int unsigned ROW_W = 12;
	localparam int unsigned COL_W = 12;
	localparam int unsigned CFG_W = 13;
	localparam int unsigned SQ_W  = 25;
	localparam int unsigned OFF_W = 26;
	localparam int unsigned PITCH_W = 15;
	localparam int unsigned CBYTE_W = 14;

	// register indexes on the configuration channel
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd2;

	// read-modify-write patterns
	localparam logic [7:0] KEEP_ALL     = 8'hFF;
	localparam logic [7:0] KEEP_NONE    = 8'h00;
	localparam logic [7:0] KEEP_LO_NIB  = 8'h0F;
	localparam logic [7:0] KEEP_HI_NIB  = 8'hF0;
	localparam logic [7:0] SET_HI_NIB   = 8'h70;
	localparam logic [7:0] SET_LO_NIB   = 8'h07;
	localparam logic [7:0] SET_BYTE     = 8'h07;
	localparam logic [7:0] SET_NONE     = 8'h00;
	localparam logic [7:0] SET_MSB      = 8'h80;

	typedef enum logic [1:0] {
		DEPTH_1,
		DEPTH_4,
		DEPTH_8,
		DEPTH_24
	} depth_t;

	// load enables of the pipeline registers held in the submodules
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	typedef struct packed {
		logic [11:0]        cx;
		logic [11:0]        cy;
		logic signed [12:0] rm1;
		logic signed [12:0] rp1;
		logic [12:0]        w;
		logic [12:0]        h;
	} ring_cfg_t;

	typedef struct packed {
		depth_t               depth;
		logic [PITCH_W-1:0]   pitch;
	} addr_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/rppd_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module rppd_ring (
	input  wire logic                          clk,
	input  wire rppd_pkg::pipe_en_t            en,
	input  wire rppd_pkg::ring_cfg_t           cfg,
	input  wire logic [rppd_pkg::ROW_W-1:0]    row,
	input  wire logic [rppd_pkg::COL_W-1:0]    col,
	output logic [rppd_pkg::OFF_W-1:0]         dist_s3,
	output logic [rppd_pkg::SQ_W-1:0]          lo_s3,
	output logic [rppd_pkg::SQ_W-1:0]          hi_s3,
	output logic                               outside_s3
);

	logic signed [12:0] dx_s1, dy_s1, rm1_s1, rp1_s1;
	logic               outside_s1, outside_s2;
	logic signed [25:0] dx_sq, dy_sq, lo_sq, hi_sq;
	logic [rppd_pkg::SQ_W-1:0] dx2_s2, dy2_s2, lo_s2, hi_s2;

	// stage 1: offsets from the center
	always_ff @(posedge clk) begin
		if (en.s1) begin
			dx_s1      <= $signed({1'b0, cfg.cx}) - $signed({1'b0, col});
			dy_s1      <= $signed({1'b0, cfg.cy}) - $signed({1'b0, row});
			rm1_s1     <= cfg.rm1;
			rp1_s1     <= cfg.rp1;
			outside_s1 <= ({1'b0, row} >= cfg.h) || ({1'b0, col} >= cfg.w);
		end
	end

	// stage 2: four squares side by side, all non-negative
	assign dx_sq = dx_s1 * dx_s1;
	assign dy_sq = dy_s1 * dy_s1;
	assign lo_sq = rm1_s1 * rm1_s1;
	assign hi_sq = rp1_s1 * rp1_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			dx2_s2     <= dx_sq[rppd_pkg::SQ_W-1:0];
			dy2_s2     <= dy_sq[rppd_pkg::SQ_W-1:0];
			lo_s2      <= lo_sq[rppd_pkg::SQ_W-1:0];
			hi_s2      <= hi_sq[rppd_pkg::SQ_W-1:0];
			outside_s2 <= outside_s1;
		end
	end

	// stage 3: squared distance
	always_ff @(posedge clk) begin
		if (en.s3) begin
			dist_s3    <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
			lo_s3      <= lo_s2;
			hi_s3      <= hi_s2;
			outside_s3 <= outside_s2;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rppd_addr.sv
`timescale 1ns / 1ps
`default_nettype none

module rppd_addr (
	input  wire logic                          clk,
	input  wire rppd_pkg::pipe_en_t            en,
	input  wire rppd_pkg::addr_cfg_t           cfg,
	input  wire logic [rppd_pkg::ROW_W-1:0]    row,
	input  wire logic [rppd_pkg::COL_W-1:0]    col,
	output logic [rppd_pkg::OFF_W-1:0]         offset_s3,
	output logic [1:0]                         count_s3,
	output logic [7:0]                         keep_s3,
	output logic [7:0]                         set_s3
);

	logic [rppd_pkg::CBYTE_W-1:0] cbyte, cbyte_s1, cbyte_s2;
	logic [7:0]                   keep, set;
	logic [1:0]                   count;
	logic [rppd_pkg::ROW_W-1:0]   row_s1;
	logic [rppd_pkg::PITCH_W-1:0] pitch_s1;
	logic [7:0]                   keep_s1, set_s1, keep_s2, set_s2;
	logic [1:0]                   count_s1, count_s2;
	logic [26:0]                  base_full;
	logic [rppd_pkg::OFF_W-1:0]   base_s2;

	// byte within the line and the byte pattern for this depth
	always_comb begin
		cbyte = '0;
		keep  = rppd_pkg::KEEP_NONE;
		set   = rppd_pkg::SET_NONE;
		count = 2'd1;
		case (cfg.depth)
			rppd_pkg::DEPTH_1: begin
				cbyte = {5'd0, col[11:3]};
				keep  = rppd_pkg::KEEP_ALL;
				set   = rppd_pkg::SET_MSB >> col[2:0];
			end
			rppd_pkg::DEPTH_4: begin
				cbyte = {3'd0, col[11:1]};
				if (col[0]) begin
					keep = rppd_pkg::KEEP_HI_NIB;
					set  = rppd_pkg::SET_LO_NIB;
				end else begin
					keep = rppd_pkg::KEEP_LO_NIB;
					set  = rppd_pkg::SET_HI_NIB;
				end
			end
			rppd_pkg::DEPTH_8: begin
				cbyte = {2'd0, col};
				set   = rppd_pkg::SET_BYTE;
			end
			default: begin
				cbyte = {1'b0, col, 1'b0} + {2'd0, col};
				count = 2'd3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			row_s1   <= row;
			pitch_s1 <= cfg.pitch;
			cbyte_s1 <= cbyte;
			keep_s1  <= keep;
			set_s1   <= set;
			count_s1 <= count;
		end
	end

	// stage 2: line base
	assign base_full = row_s1 * pitch_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			base_s2  <= base_full[rppd_pkg::OFF_W-1:0];
			cbyte_s2 <= cbyte_s1;
			keep_s2  <= keep_s1;
			set_s2   <= set_s1;
			count_s2 <= count_s1;
		end
	end

	// stage 3: byte offset, wraps at 26 bits
	always_ff @(posedge clk) begin
		if (en.s3) begin
			offset_s3 <= base_s2 + {12'd0, cbyte_s2};
			keep_s3   <= keep_s2;
			set_s3    <= set_s2;
			count_s3  <= count_s2;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ring_pixel_plotter_packed_dib.sv
// ring pixel plotter for a bottom-up packed bitmap
// s_axis carries one pixel item: tdata[11:0] row, tdata[23:12] column
// m_axis returns one result item for every pixel item, in order:
//   tuser[0] on_ring, tdata holds offset, byte count, keep mask, set bits
//   every payload field is zero on a miss
// cfg channel writes image width (index 0), height (1), bits per pixel (2);
//   cfg_ready is always high, an index beyond the list is ignored
//   write only while no pixel item is in flight
// ring center is (width/2, height/2), radius min(center) - 2, line pitch
//   rounded up to 32 bits
// pipeline: four register stages (offsets, squares and line base, distance
//   sum and byte offset, compare and output register); a result leaves the
//   output register once m_axis_tready is high
// throughput: one item per cycle while the receiver keeps m_axis_tready high
// a stalled receiver holds the output register; bubbles ahead of it still
//   collapse, so s_axis_tready only falls once all four stages are full
// reset: width 200, height 100, 4 bpp, pipeline empty
`timescale 1ns / 1ps
`default_nettype none

module ring_pixel_plotter_packed_dib #(
	parameter int unsigned MAX_SIDE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // pixel_row[11:0], pixel_column[23:12]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// byte_offset[25:0], byte_count[27:26], keep_mask[35:28], set_bits[43:36], zero pad
	output logic [47:0]      m_axis_tdata,
	output logic [0:0]       m_axis_tuser,   // on_ring[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);

	// saturation value for a side that fits the 13-bit registers
	localparam logic [12:0] SIDE_CLIP = (MAX_SIDE > 8191) ? 13'h1FFF : 13'(MAX_SIDE);

	logic [12:0] width_q, height_q;
	logic [4:0]  bpp_q;

	logic [12:0] w_eff, h_eff;
	logic [11:0] cmin;
	logic [17:0] line_bits;
	logic [17:0] line_round;
	rppd_pkg::depth_t    depth;
	rppd_pkg::ring_cfg_t ring_cfg;
	rppd_pkg::addr_cfg_t addr_cfg;
	rppd_pkg::pipe_en_t  en;
	logic                en4;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [rppd_pkg::OFF_W-1:0] dist_s3, offset_s3;
	logic [rppd_pkg::SQ_W-1:0]  lo_s3, hi_s3;
	logic                       outside_s3;
	logic [1:0]                 count_s3;
	logic [7:0]                 keep_s3, set_s3;
	logic                       hit;

	logic                       on_ring_s4;
	logic [rppd_pkg::OFF_W-1:0] offset_s4;
	logic [1:0]                 count_s4;
	logic [7:0]                 keep_s4, set_s4;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd200;
			height_q <= 13'd100;
			bpp_q    <= 5'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				rppd_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_data;
				rppd_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data;
				rppd_pkg::REG_BITS_PER_PIXEL: bpp_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// values derived from configuration; static while items flow only if the user writes cfg while idle, not enforced here
	assign w_eff = ({19'd0, width_q} > 32'(MAX_SIDE)) ? SIDE_CLIP : width_q;
	assign h_eff = ({19'd0, height_q} > 32'(MAX_SIDE)) ? SIDE_CLIP : height_q;
	assign cmin  = (w_eff[12:1] < h_eff[12:1]) ? w_eff[12:1] : h_eff[12:1];

	always_comb begin
		case (bpp_q)
			5'd1:    depth = rppd_pkg::DEPTH_1;
			5'd4:    depth = rppd_pkg::DEPTH_4;
			5'd8:    depth = rppd_pkg::DEPTH_8;
			default: depth = rppd_pkg::DEPTH_24;
		endcase
	end

	// bits per line; depths are fixed, so shifts and one add
	always_comb begin
		case (depth)
			rppd_pkg::DEPTH_1: line_bits = {5'd0, w_eff};
			rppd_pkg::DEPTH_4: line_bits = {3'd0, w_eff, 2'd0};
			rppd_pkg::DEPTH_8: line_bits = {2'd0, w_eff, 3'd0};
			default:           line_bits = {1'b0, w_eff, 4'd0} + {2'd0, w_eff, 3'd0};
		endcase
	end

	assign line_round = line_bits + 18'd31;

	assign ring_cfg.cx  = w_eff[12:1];
	assign ring_cfg.cy  = h_eff[12:1];
	// radius minus one and plus one
	assign ring_cfg.rm1 = $signed({1'b0, cmin} - 13'd3);
	assign ring_cfg.rp1 = $signed({1'b0, cmin} - 13'd1);
	assign ring_cfg.w   = w_eff;
	assign ring_cfg.h   = h_eff;

	assign addr_cfg.depth = depth;
	assign addr_cfg.pitch = {line_round[17:5], 2'b00};

	// stage enables: a stage loads when empty or when the next one moves
	assign en4           = !valid_s4 || m_axis_tready;
	assign en.s3         = !valid_s3 || en4;
	assign en.s2         = !valid_s2 || en.s3;
	assign en.s1         = !valid_s1 || en.s2;
	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_axis_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en4)   valid_s4 <= valid_s3;
		end
	end

	rppd_ring u_ring (
		.clk        (clk),
		.en         (en),
		.cfg        (ring_cfg),
		.row        (s_axis_tdata[11:0]),
		.col        (s_axis_tdata[23:12]),
		.dist_s3    (dist_s3),
		.lo_s3      (lo_s3),
		.hi_s3      (hi_s3),
		.outside_s3 (outside_s3)
	);

	rppd_addr u_addr (
		.clk       (clk),
		.en        (en),
		.cfg       (addr_cfg),
		.row       (s_axis_tdata[11:0]),
		.col       (s_axis_tdata[23:12]),
		.offset_s3 (offset_s3),
		.count_s3  (count_s3),
		.keep_s3   (keep_s3),
		.set_s3    (set_s3)
	);

	// stage 4: strict ring test, misses give an all-zero item
	assign hit = !outside_s3 && (dist_s3 > {1'b0, lo_s3}) && (dist_s3 < {1'b0, hi_s3});

	always_ff @(posedge clk) begin
		if (en4) begin
			on_ring_s4 <= hit;
			offset_s4  <= hit ? offset_s3 : '0;
			count_s4   <= hit ? count_s3 : 2'd0;
			keep_s4    <= hit ? keep_s3 : 8'd0;
			set_s4     <= hit ? set_s3 : 8'd0;
		end
	end

	assign m_axis_tvalid   = valid_s4;
	assign m_axis_tuser[0] = on_ring_s4;
	assign m_axis_tdata    = {4'd0, set_s4, keep_s4, count_s4, offset_s4};

`ifndef SYNTHESIS
	// input only backs up once every stage holds an item
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a bubble in the pipeline");

	// a miss carries no write
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 48'd0))
		else $error("miss item with nonzero payload");

	// a hit always modifies at least one byte
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[27:26] != 2'd0))
		else $error("hit item with zero byte count");

	// three-byte writes are black pixels
	a_rgb_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[27:26] == 2'd3)
			|-> (m_axis_tdata[43:28] == 16'd0))
		else $error("24 bpp item with nonzero mask or bits");
`endif

endmodule

`default_nettype wire
